// ----- design/mpd_pkg.sv -----
// Package for the max-pooling downsampler: beat payload types, the
// decoded control struct passed between stages, and register constants.
// No dependencies.
package mpd_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;

    // Configuration register indexes.
    localparam logic REG_POOL_MODE   = 1'b0;
    localparam logic REG_IMAGE_WIDTH = 1'b1;

    // Configuration reset values.
    localparam logic             POOL_MODE_RESET   = 1'b1;
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 12'd1280;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pooled_value;
        logic             row_end;
    } pool_out_t;

    // Position of one accepted pixel within its pooling block.
    typedef struct packed {
        logic frame_start;
        logic in_block;
        logic col_first;
        logic col_last;
        logic phase_first;
        logic phase_last;
        logic row_end;
    } ctrl_t;

endpackage

// ----- design/max_pool_downsample.sv -----
// Max-pooling downsampler, 2x2 or 4x4 block maximum over an 8-bit pixel stream.
// Throughput: one pixel beat per cycle, held off while a finished block waits on a full
// result register. The line store has one write and one read port. A pooled value
// passes the pixel stage, then the result register, once its last pixel is accepted.
// Reset: counters cleared, pool_mode = 4x4, image_width = 1280; the line store
// is not cleared and no beat is held off after reset.
// Uses mpd_pkg, mpd_ctrl and mpd_datapath.
module max_pool_downsample #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mpd_pkg::pix_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mpd_pkg::pool_out_t        out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [mpd_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH / 2);

    logic                      pool_mode_reg;
    logic [mpd_pkg::CFG_W-1:0] image_width_reg;
    logic                      accept;
    mpd_pkg::ctrl_t            ctrl;
    logic [AW-1:0]             idx;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_mode_reg   <= mpd_pkg::POOL_MODE_RESET;
            image_width_reg <= mpd_pkg::IMAGE_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mpd_pkg::REG_POOL_MODE:   pool_mode_reg   <= cfg_data[0];
                mpd_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    mpd_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (in_data.frame_start),
        .pool_mode   (pool_mode_reg),
        .image_width (image_width_reg),
        .ctrl        (ctrl),
        .idx         (idx)
    );

    mpd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (in_data.pixel),
        .ctrl      (ctrl),
        .idx       (idx),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- design/mpd_ctrl.sv -----
// Column and row-phase counters of the max-pooling downsampler, with the
// decode of each accepted pixel's position in its block. Uses mpd_pkg.
module mpd_ctrl #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               frame_start,
    input  logic                               pool_mode,
    input  logic [mpd_pkg::CFG_W-1:0]          image_width,
    output mpd_pkg::ctrl_t                     ctrl,
    output logic [$clog2(MAX_WIDTH/2)-1:0]     idx
);

    localparam int AW   = $clog2(MAX_WIDTH / 2);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > mpd_pkg::CFG_W) ? WW : mpd_pkg::CFG_W;

    logic [CW-1:0]   col_reg, col_next;
    logic [1:0]      row_phase_reg, row_phase_next;

    logic [CMPW-1:0] width_ext, w_eff, blocks, col_inc, ocol_ext;
    logic [CW-1:0]   col_eff, ocol;
    logic [1:0]      xin, bmask, phase;
    logic            wrap;

    always_comb
    begin
        width_ext = CMPW'(image_width);
        if (width_ext > CMPW'(MAX_WIDTH))
            w_eff = CMPW'(MAX_WIDTH);
        else if (width_ext == '0)
            w_eff = CMPW'(1);
        else
            w_eff = width_ext;

        col_eff = frame_start ? '0 : col_reg;
        bmask   = pool_mode ? 2'b11 : 2'b01;
        blocks  = pool_mode ? (w_eff >> 2) : (w_eff >> 1);
        ocol    = pool_mode ? (col_eff >> 2) : (col_eff >> 1);
        xin     = col_eff[1:0] & bmask;
        phase   = (frame_start ? 2'b00 : row_phase_reg) & bmask;

        ocol_ext = CMPW'(ocol);
        ctrl.frame_start = frame_start;
        ctrl.in_block    = ocol_ext < blocks;
        ctrl.row_end     = ocol_ext == (blocks - CMPW'(1));
        ctrl.col_first   = xin == 2'b00;
        ctrl.col_last    = xin == bmask;
        ctrl.phase_first = phase == 2'b00;
        ctrl.phase_last  = phase == bmask;
        idx = ocol[AW-1:0];

        // A column at or past the width ends the row, even after a width change.
        col_inc = CMPW'(col_eff) + CMPW'(1);
        wrap    = col_inc >= w_eff;
        if (wrap)
        begin
            col_next       = '0;
            row_phase_next = (phase + 2'b01) & bmask;
        end
        else
        begin
            col_next       = col_inc[CW-1:0];
            row_phase_next = phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_phase_reg <= '0;
        end
        else if (accept)
        begin
            col_reg       <= col_next;
            row_phase_reg <= row_phase_next;
        end
    end

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(col_reg) < CMPW'(MAX_WIDTH))
        else $error("column counter beyond maximum width");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_start) |=> (col_reg <= CW'(1)))
        else $error("frame start did not restart the column counter");

endmodule

// ----- design/mpd_datapath.sv -----
// Pixel stage, line store and result register of the max-pooling
// downsampler: running horizontal maximum and per-column block maxima.
// Uses mpd_pkg; position decode comes from mpd_ctrl.
module mpd_datapath #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mpd_pkg::PIX_W-1:0]          pixel,
    input  mpd_pkg::ctrl_t                     ctrl,
    input  logic [$clog2(MAX_WIDTH/2)-1:0]     idx,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mpd_pkg::pool_out_t                 out_data
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = $clog2(DEPTH);

    logic [mpd_pkg::PIX_W-1:0] mem [DEPTH];
    logic [mpd_pkg::PIX_W-1:0] rd_reg;

    logic                      s1_valid_reg, s1_valid_next;
    logic [mpd_pkg::PIX_W-1:0] s1_pixel_reg;
    mpd_pkg::ctrl_t            s1_ctrl_reg;
    logic [AW-1:0]             s1_idx_reg;

    logic [mpd_pkg::PIX_W-1:0] hmax_reg, hmax_next;
    logic                      out_valid_reg, out_valid_next;
    mpd_pkg::pool_out_t        out_data_reg;

    logic                      accept, s1_result, s1_adv, mem_we;
    logic [mpd_pkg::PIX_W-1:0] hbase, h, vmax, v;

    always_comb
    begin
        s1_result = s1_ctrl_reg.in_block && s1_ctrl_reg.col_last && s1_ctrl_reg.phase_last;
        s1_adv    = s1_valid_reg && (!s1_result || !out_valid_reg || out_ready);
        in_ready  = !s1_valid_reg || s1_adv;
        accept    = in_valid && in_ready;

        // Frame start clears the running maximum before this pixel is folded in.
        hbase = s1_ctrl_reg.frame_start ? '0 : hmax_reg;
        h     = s1_ctrl_reg.col_first ? s1_pixel_reg
              : ((hbase > s1_pixel_reg) ? hbase : s1_pixel_reg);
        hmax_next = s1_ctrl_reg.in_block ? h : hbase;

        vmax = (rd_reg > h) ? rd_reg : h;
        v    = s1_ctrl_reg.phase_first ? h : vmax;

        mem_we = s1_adv && s1_ctrl_reg.in_block && s1_ctrl_reg.col_last
                 && !s1_ctrl_reg.phase_last;

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv && s1_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // The line store is read when a pixel is taken; the entry it needs was
    // written at least one full row earlier.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[s1_idx_reg] <= v;
        if (accept)
            rd_reg <= mem[idx];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_ctrl_reg  <= ctrl;
            s1_idx_reg   <= idx;
        end
        if (s1_adv && s1_result)
        begin
            out_data_reg.pooled_value <= v;
            out_data_reg.row_end      <= s1_ctrl_reg.row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hmax_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
                hmax_reg <= hmax_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !in_ready)
        else $error("pixel taken while the pixel stage is stalled");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_result) |=> out_valid_reg)
        else $error("completed block did not reach the result register");

    a_store_not_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (s1_valid_reg && !s1_result))
        else $error("line store written on a block that emits a result");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for max_pool_downsample: 2x2 and 4x4 block maxima over a raster
// pixel stream, with a built-in predictor and a scoreboard class compared beat by beat.
// Depends on mpd_pkg and the max_pool_downsample RTL only.
module testbench;

    localparam int MAX_W        = 2048;
    localparam int STORE_DEPTH  = MAX_W / 2;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int WIDE_ITEMS   = 128;
    localparam int RANDOM_ITEMS = 350;
    localparam int RANDOM_CAP   = 400;

    localparam logic MODE_2X2 = 1'b0;
    localparam logic MODE_4X4 = 1'b1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // Predicts pooled values from accepted pixels and checks the results in order.
    class pool_scoreboard;
        logic                      pool_mode;
        logic [mpd_pkg::CFG_W-1:0] image_width;
        logic [10:0]               column_count;
        logic [1:0]                row_phase;
        logic [7:0]                horizontal_max;
        logic [7:0]                column_max [STORE_DEPTH];
        bit                        written [STORE_DEPTH];
        mpd_pkg::pool_out_t        expected_q [$];
        int                        n_errors;
        int                        n_checked;
        int                        n_pixels;

        function new();
            pool_mode      = mpd_pkg::POOL_MODE_RESET;
            image_width    = mpd_pkg::IMAGE_WIDTH_RESET;
            column_count   = '0;
            row_phase      = '0;
            horizontal_max = '0;
            n_errors       = 0;
            n_checked      = 0;
            n_pixels       = 0;
        endfunction

        function void set_reg(logic idx, logic [mpd_pkg::CFG_W-1:0] val);
            if (idx == mpd_pkg::REG_POOL_MODE)
                pool_mode = val[0];
            else
                image_width = val;
        endfunction

        function int unsigned eff_width();
            if (image_width > MAX_W)
                return MAX_W;
            if (image_width == 0)
                return 1;
            return image_width;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // True when this beat would merge with a line store entry never written.
        function bit reads_unwritten(mpd_pkg::pix_in_t p);
            int unsigned sh;
            int unsigned bsize;
            int unsigned col;
            int unsigned phase;
            if (p.frame_start)
                return 1'b0;
            sh    = (pool_mode == MODE_4X4) ? 2 : 1;
            bsize = 1 << sh;
            col   = column_count;
            phase = row_phase & (bsize - 1);
            return ((col >> sh) < (eff_width() >> sh)) && ((col & (bsize - 1)) == bsize - 1)
                   && (phase != 0) && !written[col >> sh];
        endfunction

        function void note_pixel(mpd_pkg::pix_in_t p);
            int unsigned        sh;
            int unsigned        bsize;
            int unsigned        w;
            int unsigned        blocks;
            int unsigned        col;
            int unsigned        xin;
            int unsigned        ocol;
            int unsigned        phase;
            logic [7:0]         h;
            logic [7:0]         v;
            mpd_pkg::pool_out_t r;
            n_pixels++;
            sh    = (pool_mode == MODE_4X4) ? 2 : 1;
            bsize = 1 << sh;
            w     = eff_width();
            if (p.frame_start)
            begin
                column_count   = '0;
                row_phase      = '0;
                horizontal_max = '0;
            end
            blocks = w >> sh;
            col    = column_count;
            xin    = col & (bsize - 1);
            ocol   = col >> sh;
            phase  = row_phase & (bsize - 1);
            if (ocol < blocks)
            begin
                h = (xin == 0 || p.pixel > horizontal_max) ? p.pixel : horizontal_max;
                horizontal_max = h;
                if (xin == bsize - 1)
                begin
                    v = (phase == 0 || h > column_max[ocol]) ? h : column_max[ocol];
                    if (phase == bsize - 1)
                    begin
                        r.pooled_value = v;
                        r.row_end      = (ocol == blocks - 1);
                        expected_q.push_back(r);
                    end
                    else
                    begin
                        column_max[ocol] = v;
                        written[ocol]    = 1'b1;
                    end
                end
            end
            if (col + 1 >= w)
            begin
                column_count = '0;
                row_phase    = 2'((phase + 1) & (bsize - 1));
            end
            else
            begin
                column_count = 11'(col + 1);
                row_phase    = 2'(phase);
            end
        endfunction

        function void report(string what, int want, int got);
            n_errors++;
            $display("%0t ERROR %s expected %0d actual %0d", $time, what, want, got);
        endfunction

        function void check_result(mpd_pkg::pool_out_t got);
            mpd_pkg::pool_out_t want;
            if (expected_q.size() == 0)
            begin
                report("pooled beat with none expected, value", -1, got.pooled_value);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.pooled_value !== want.pooled_value)
                report("pooled_value", want.pooled_value, got.pooled_value);
            if (got.row_end !== want.row_end)
                report("row_end", want.row_end, got.row_end);
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    mpd_pkg::pix_in_t          in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    mpd_pkg::pool_out_t        out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic                      cfg_index = mpd_pkg::REG_POOL_MODE;
    logic [mpd_pkg::CFG_W-1:0] cfg_data  = '0;

    pool_scoreboard sb;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int cycle_count  = 0;

    max_pool_downsample #(.MAX_WIDTH(MAX_W)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("FAIL max_pool_downsample");
            $finish;
        end
    end

    // Output side: check each accepted beat, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic set_idle(idle_mode_e m);
        case (m)
            IDLE_SENDER:
            begin
                send_gap_pct = 72;
                stall_pct    = 0;
            end
            IDLE_RECEIVER:
            begin
                send_gap_pct = 0;
                stall_pct    = 72;
            end
            IDLE_BOTH:
            begin
                send_gap_pct = 22;
                stall_pct    = 22;
            end
            default:
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
        endcase
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
    endtask

    task automatic push_pixel(logic [7:0] value, logic fs);
        mpd_pkg::pix_in_t p;
        p.pixel       = value;
        p.frame_start = fs;
        idle_gap();
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(p);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(logic idx, logic [mpd_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic mode, logic [mpd_pkg::CFG_W-1:0] width, bit set_mode,
                             bit set_width);
        if (set_mode)
            write_reg(mpd_pkg::REG_POOL_MODE, mpd_pkg::CFG_W'(mode));
        if (set_width)
            write_reg(mpd_pkg::REG_IMAGE_WIDTH, width);
        cfg_valid <= 1'b0;
    endtask

    // The block may still be busy with beats that produce nothing, hence the tail.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic stream(int n, bit open_frame, int noise_pct);
        mpd_pkg::pix_in_t p;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                p.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                p.pixel = 8'($urandom_range(0, 255));
            p.frame_start = (i == 0 && open_frame) || ($urandom_range(0, 99) < noise_pct);
            // A fresh frame keeps the line store from being read before it is filled.
            if (sb.reads_unwritten(p))
                p.frame_start = 1'b1;
            push_pixel(p.pixel, p.frame_start);
        end
    endtask

    initial
    begin
        logic [7:0]                first_frame [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                                                       8'h01, 8'h00, 8'hAA, 8'h55};
        int                        settings;
        int                        random_items;
        int                        n;
        int unsigned               eff;
        int unsigned               bsize;
        logic                      mode;
        logic [mpd_pkg::CFG_W-1:0] width;
        bit                        open_frame;

        sb = new();
        settings = 0;
        random_items = 0;
        set_idle(IDLE_NONE);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a width of 4 in both modes, extreme and alternating pixels.
        configure(MODE_2X2, 12'd4, 1'b1, 1'b1);
        settings++;
        foreach (first_frame[i])
            push_pixel(first_frame[i], i == 0);
        drain();
        configure(MODE_4X4, 12'd4, 1'b1, 1'b0);
        settings++;
        for (int i = 0; i < 16; i++)
            push_pixel((i == 9) ? 8'hC3 : 8'(i * 3), i == 0);
        drain();

        // Widest image, with a width beyond the maximum that must clamp.
        set_idle(IDLE_BOTH);
        configure(MODE_2X2, 12'd4095, 1'b1, 1'b1);
        settings++;
        stream(WIDE_ITEMS, 1'b1, 0);
        drain();

        while (random_items < RANDOM_ITEMS)
        begin
            set_idle(idle_mode_e'(settings % 4));
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0, 1:    width = mpd_pkg::CFG_W'($urandom_range(0, 3));
                2, 3:    width = mpd_pkg::CFG_W'($urandom_range(MAX_W + 1, 4095));
                4:       width = mpd_pkg::CFG_W'(MAX_W);
                5, 6:    width = mpd_pkg::CFG_W'($urandom_range(13, 40));
                default: width = mpd_pkg::CFG_W'($urandom_range(4, 12));
            endcase
            open_frame = ($urandom_range(0, 9) < 7);
            if (open_frame)
                configure(mode, width, 1'b1, 1'b1);
            else if ($urandom_range(0, 1))
                configure(mode, width, 1'b1, 1'b0);
            else
                configure(mode, width, 1'b0, 1'b1);
            settings++;
            eff   = sb.eff_width();
            bsize = (sb.pool_mode == MODE_4X4) ? 4 : 2;
            if (eff > 64)
                n = $urandom_range(1, 150);
            else if (eff < bsize)
                n = $urandom_range(1, 16);
            else
                n = eff * (bsize + $urandom_range(0, bsize)) + $urandom_range(0, eff - 1);
            if (n > RANDOM_CAP - random_items)
                n = RANDOM_CAP - random_items;
            stream(n, open_frame, 3);
            random_items += n;
            drain();
        end

        $display("Covered %0d pixel beats and %0d pooled results over %0d mode and width",
                 sb.n_pixels, sb.n_checked, settings);
        $display("settings, including clamped, zero and sub-block widths and mid-frame changes.");
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("PASS max_pool_downsample");
        else
            $display("FAIL max_pool_downsample");
        $finish;
    end
endmodule
